// File: rtl/awm_pkg.sv
// ----------------------------------------------------------------------------
// awm_pkg
// Shared constants, codes and types of the anagram window matcher.
// ----------------------------------------------------------------------------
package awm_pkg;

	localparam int MAX_PATTERN_DEF = 64;
	localparam int ALPHABET_DEF    = 26;

	localparam int CMD_W    = 2;
	localparam int LETTER_W = 5;
	localparam int POS_W    = 32;

	localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_PATTERN = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TEXT    = 2'd2;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_CLEAR,
		OP_PAT,
		OP_TEXT
	} op_t;

	// one request as it moves down the histogram pipeline
	typedef struct packed {
		op_t                 op;
		logic [LETTER_W-1:0] letter;
		logic                act;    // text letter with a nonempty pattern
		logic                rm;     // window full, oldest letter leaves
		logic                full;   // window full after this letter
		logic [POS_W-1:0]    start;
	} item_t;

	typedef struct packed {
		logic             match;
		logic [POS_W-1:0] start;
		logic [POS_W-1:0] total;
	} res_t;

endpackage

// File: rtl/awm_hist.sv
// ----------------------------------------------------------------------------
// awm_hist
// Histogram engine: pattern, added and removed letter counts in three
// memories, read in one stage and updated in the next with forwarding.
// ----------------------------------------------------------------------------
module awm_hist #(
	parameter int MAX_PATTERN = awm_pkg::MAX_PATTERN_DEF,
	parameter int ALPHABET    = awm_pkg::ALPHABET_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  awm_pkg::item_t                item_s1,
	input  logic [awm_pkg::LETTER_W-1:0]  old_s1,
	output logic                          res_valid,
	output awm_pkg::res_t                 res
);
	import awm_pkg::*;

	localparam int AW = $clog2(ALPHABET);
	localparam int CW = $clog2(MAX_PATTERN + 1);
	localparam int MW = $clog2(ALPHABET + 1);

	logic [CW-1:0] add_mem [ALPHABET];
	logic [CW-1:0] rem_mem [ALPHABET];
	logic [CW-1:0] pat_mem [ALPHABET];

	logic [ALPHABET-1:0] add_v_q, rem_v_q, pat_v_q;

	item_t               item_s2;
	logic [LETTER_W-1:0] old_s2;
	logic [CW-1:0]       add_c_s2, add_o_s2, rem_c_s2, rem_o_s2, pat_c_s2, pat_o_s2;

	logic          fa_v_q, fr_v_q, fp_v_q;
	logic [AW-1:0] fa_addr_q, fr_addr_q, fp_addr_q;
	logic [CW-1:0] fa_data_q, fr_data_q, fp_data_q;

	logic [MW-1:0]    mismatch_q, distinct_q;
	logic [POS_W-1:0] found_q;

	logic [AW-1:0]    ca1, oa1, ca2, oa2;
	logic [CW-1:0]    ac, ao, rc, ro, pc, po;
	logic [CW-1:0]    wc, wo, wc_inc, wo_dec, ac_inc, ro_inc, pc_inc;
	logic             is_text, same, add_up, add_dn, rm_up, rm_dn, match;
	logic [1:0]       up_cnt, dn_cnt;
	logic [MW-1:0]    mis_n, distinct_n;
	logic [POS_W-1:0] found_n;

	assign ca1 = AW'(item_s1.letter);
	assign oa1 = AW'(old_s1);

	always_comb begin
		ca2 = AW'(item_s2.letter);
		oa2 = AW'(old_s2);

		ac = (fa_v_q && fa_addr_q == ca2) ? fa_data_q : (add_v_q[ca2] ? add_c_s2 : '0);
		ao = (fa_v_q && fa_addr_q == oa2) ? fa_data_q : (add_v_q[oa2] ? add_o_s2 : '0);
		rc = (fr_v_q && fr_addr_q == ca2) ? fr_data_q : (rem_v_q[ca2] ? rem_c_s2 : '0);
		ro = (fr_v_q && fr_addr_q == oa2) ? fr_data_q : (rem_v_q[oa2] ? rem_o_s2 : '0);
		pc = (fp_v_q && fp_addr_q == ca2) ? fp_data_q : (pat_v_q[ca2] ? pat_c_s2 : '0);
		po = (fp_v_q && fp_addr_q == oa2) ? fp_data_q : (pat_v_q[oa2] ? pat_o_s2 : '0);

		wc     = CW'(ac - rc);
		wo     = CW'(ao - ro);
		wc_inc = CW'(wc + 1'b1);
		wo_dec = CW'(wo - 1'b1);
		ac_inc = CW'(ac + 1'b1);
		ro_inc = CW'(ro + 1'b1);
		pc_inc = CW'(pc + 1'b1);

		is_text = (item_s2.op == OP_TEXT) && item_s2.act;
		// same letter enters and leaves: window unchanged
		same    = item_s2.rm && (item_s2.letter == old_s2);

		add_up = is_text && !same && (wc == pc) && (wc_inc != pc);
		add_dn = is_text && !same && (wc != pc) && (wc_inc == pc);
		rm_up  = is_text && !same && item_s2.rm && (wo == po) && (wo_dec != po);
		rm_dn  = is_text && !same && item_s2.rm && (wo != po) && (wo_dec == po);

		up_cnt = {1'b0, add_up} + {1'b0, rm_up};
		dn_cnt = {1'b0, add_dn} + {1'b0, rm_dn};
		mis_n  = MW'(mismatch_q + MW'(up_cnt) - MW'(dn_cnt));

		match   = is_text && item_s2.full && (mis_n == '0);
		found_n = (match && found_q != '1) ? POS_W'(found_q + 1'b1) : found_q;

		distinct_n = (pc == '0) ? MW'(distinct_q + 1'b1) : distinct_q;
	end

	assign res_valid   = item_s2.op == OP_TEXT;
	assign res.match   = match;
	assign res.start   = item_s2.start;
	assign res.total   = found_n;

	// memories: registered reads, read-before-write
	always_ff @(posedge clk) begin
		if (adv) begin
			old_s2   <= old_s1;
			add_c_s2 <= add_mem[ca1];
			add_o_s2 <= add_mem[oa1];
			rem_c_s2 <= rem_mem[ca1];
			rem_o_s2 <= rem_mem[oa1];
			pat_c_s2 <= pat_mem[ca1];
			pat_o_s2 <= pat_mem[oa1];
			if (is_text)
				add_mem[ca2] <= ac_inc;
			if (is_text && item_s2.rm)
				rem_mem[oa2] <= ro_inc;
			if (item_s2.op == OP_PAT)
				pat_mem[ca2] <= pc_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s2    <= '0;
			add_v_q    <= '0;
			rem_v_q    <= '0;
			pat_v_q    <= '0;
			fa_v_q     <= 1'b0;
			fr_v_q     <= 1'b0;
			fp_v_q     <= 1'b0;
			mismatch_q <= '0;
			distinct_q <= '0;
			found_q    <= '0;
		end else if (adv) begin
			item_s2 <= item_s1;
			fa_v_q  <= is_text;
			fr_v_q  <= is_text && item_s2.rm;
			fp_v_q  <= item_s2.op == OP_PAT;
			unique case (item_s2.op)
				OP_CLEAR: begin
					add_v_q    <= '0;
					rem_v_q    <= '0;
					pat_v_q    <= '0;
					mismatch_q <= '0;
					distinct_q <= '0;
					found_q    <= '0;
				end
				OP_PAT: begin
					pat_v_q[ca2] <= 1'b1;
					add_v_q      <= '0;
					rem_v_q      <= '0;
					distinct_q   <= distinct_n;
					mismatch_q   <= distinct_n;
					fp_addr_q    <= ca2;
					fp_data_q    <= pc_inc;
				end
				OP_TEXT: begin
					if (is_text) begin
						add_v_q[ca2] <= 1'b1;
						fa_addr_q    <= ca2;
						fa_data_q    <= ac_inc;
						mismatch_q   <= mis_n;
						found_q      <= found_n;
						if (item_s2.rm) begin
							rem_v_q[oa2] <= 1'b1;
							fr_addr_q    <= oa2;
							fr_data_q    <= ro_inc;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// File: rtl/anagram_window_matcher_top.sv
// ----------------------------------------------------------------------------
// anagram_window_matcher_top
// Sliding window anagram search over a stream of letter indices.
//
//   Channel   Handshake              Payload
//   request   cmd_valid / cmd_stall  cmd, letter
//   result    res_valid / res_stall  window_match, window_start, match_total
//
// One request per cycle sustained unless the output buffer fills. A text
// letter's result is registered in item_s1, item_s2 and the output register;
// the forwarded histogram read-modify-write in stage two sets that rate.
// Reset and clear empty the histograms at once through per-entry valid bits.
// A two-entry output buffer absorbs result stalls; cmd_stall rises only when
// both entries hold results.
// ----------------------------------------------------------------------------
module anagram_window_matcher_top #(
	parameter int MAX_PATTERN = awm_pkg::MAX_PATTERN_DEF,
	parameter int ALPHABET    = awm_pkg::ALPHABET_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_stall,
	input  logic [awm_pkg::CMD_W-1:0]     cmd,
	input  logic [awm_pkg::LETTER_W-1:0]  letter,
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic                          window_match,
	output logic [awm_pkg::POS_W-1:0]     window_start,
	output logic [awm_pkg::POS_W-1:0]     match_total
);
	import awm_pkg::*;

	localparam int CW = $clog2(MAX_PATTERN + 1);
	localparam int RW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam logic [CW:0]   MAX_X  = (CW+1)'(MAX_PATTERN);
	localparam logic [RW-1:0] PTR_LAST = RW'(MAX_PATTERN - 1);
	localparam logic [CW-1:0] LEN_MAX  = CW'(MAX_PATTERN);

	logic [LETTER_W-1:0] ring_mem [MAX_PATTERN];

	logic [CW-1:0]    len_q, fill_q;
	logic [RW-1:0]    ptr_q;
	logic [POS_W-1:0] pos_q;

	item_t               item_d, item_s1;
	logic [LETTER_W-1:0] old_s1;

	logic       adv, accept, in_rng, ring_wr;
	logic [CW:0] ptr_x, len_x, slot;
	logic [RW-1:0] old_idx;

	logic          [CW-1:0] len_d, fill_d;
	logic          [RW-1:0] ptr_d;
	logic          [POS_W-1:0] pos_d;

	logic  h_valid;
	res_t  h_res;
	res_t  head_q, skid_q;
	logic  head_v_q, skid_v_q, pop, push;

	assign adv       = !skid_v_q;
	assign cmd_stall = skid_v_q;
	assign accept    = cmd_valid && !cmd_stall;
	assign in_rng    = 32'(letter) < 32'(ALPHABET);

	assign ptr_x   = (CW+1)'(ptr_q);
	assign len_x   = (CW+1)'(len_q);
	assign slot    = (ptr_x >= len_x) ? ptr_x - len_x : ptr_x + MAX_X - len_x;
	assign old_idx = slot[RW-1:0];

	always_comb begin
		item_d        = '0;
		item_d.op     = OP_NONE;
		item_d.letter = letter;
		len_d         = len_q;
		fill_d        = fill_q;
		ptr_d         = ptr_q;
		pos_d         = pos_q;
		ring_wr       = 1'b0;
		unique case (cmd)
			CMD_CLEAR: begin
				item_d.op = OP_CLEAR;
				len_d     = '0;
				fill_d    = '0;
				ptr_d     = '0;
				pos_d     = '0;
			end
			CMD_PATTERN: begin
				if (in_rng && len_q != LEN_MAX) begin
					item_d.op = OP_PAT;
					len_d     = CW'(len_q + 1'b1);
					fill_d    = '0;
					pos_d     = '0;
				end
			end
			CMD_TEXT: begin
				if (in_rng) begin
					item_d.op = OP_TEXT;
					ring_wr   = 1'b1;
					ptr_d     = (ptr_q == PTR_LAST) ? '0 : RW'(ptr_q + 1'b1);
					pos_d     = POS_W'(pos_q + 1'b1);
					if (len_q != '0) begin
						item_d.act  = 1'b1;
						item_d.rm   = fill_q >= len_q;
						item_d.full = item_d.rm || (CW'(fill_q + 1'b1) == len_q);
						if (!item_d.rm)
							fill_d = CW'(fill_q + 1'b1);
						if (item_d.full)
							item_d.start = POS_W'(pos_q - POS_W'(len_q) + 1'b1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			old_s1 <= ring_mem[old_idx];
			if (ring_wr)
				ring_mem[ptr_q] <= letter;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			fill_q  <= '0;
			ptr_q   <= '0;
			pos_q   <= '0;
			item_s1 <= '0;
		end else if (adv) begin
			if (accept) begin
				len_q   <= len_d;
				fill_q  <= fill_d;
				ptr_q   <= ptr_d;
				pos_q   <= pos_d;
				item_s1 <= item_d;
			end else begin
				item_s1.op <= OP_NONE;
			end
		end
	end

	awm_hist #(
		.MAX_PATTERN (MAX_PATTERN),
		.ALPHABET    (ALPHABET)
	) u_hist (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.item_s1   (item_s1),
		.old_s1    (old_s1),
		.res_valid (h_valid),
		.res       (h_res)
	);

	// two-entry output buffer
	assign push = adv && h_valid;
	assign pop  = head_v_q && !res_stall;

	always_ff @(posedge clk) begin
		if (!head_v_q || pop)
			head_q <= skid_v_q ? skid_q : h_res;
		if (head_v_q && !pop && push)
			skid_q <= h_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (!head_v_q || pop) begin
				head_v_q <= skid_v_q || push;
				skid_v_q <= 1'b0;
			end else if (push) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	assign res_valid    = head_v_q;
	assign window_match = head_q.match;
	assign window_start = head_q.start;
	assign match_total  = head_q.total;

endmodule
